// ===== sv/block_range_fragment_splitter_defines.svh =====
`ifndef BLOCK_RANGE_FRAGMENT_SPLITTER_DEFINES_SVH
`define BLOCK_RANGE_FRAGMENT_SPLITTER_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define BRFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off during rst
`define BRFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/brfs_pkg.sv =====
package brfs_pkg;

  localparam int OFS_W   = 48;
  localparam int BLK_W   = 33;
  localparam int INBLK_W = 32;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 2;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_FILE_LENGTH  = 2'd0;
  localparam reg_idx_t REG_BLOCK_LENGTH = 2'd1;

  localparam logic [OFS_W-1:0] FILE_LENGTH_RST  = 48'd1;
  localparam logic [BLK_W-1:0] BLOCK_LENGTH_RST = 33'd1048576;

  typedef struct packed {
    logic go;
    logic done;
  } rem_ctl_t;

endpackage

// ===== sv/brfs_rng_if.sv =====
interface brfs_rng_if import brfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] range_start;
  logic [OFS_W-1:0] range_length;

  modport source (output valid, range_start, range_length, input ready);
  modport sink   (input valid, range_start, range_length, output ready);
endinterface

// ===== sv/brfs_frag_if.sv =====
interface brfs_frag_if import brfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OFS_W-1:0]   block_base;
  logic [BLK_W-1:0]   block_valid;
  logic [INBLK_W-1:0] offset_in_block;
  logic [BLK_W-1:0]   piece_length;
  logic [OFS_W-1:0]   data_offset;
  logic               whole_block;
  logic               last_piece;
  logic [CNT_W-1:0]   whole_count;
  logic [OFS_W-1:0]   whole_bytes;
  logic [CNT_W-1:0]   part_count;
  logic [OFS_W-1:0]   part_bytes;
  logic               bad_range;

  modport source (
    output valid, block_base, block_valid, offset_in_block, piece_length, data_offset,
           whole_block, last_piece, whole_count, whole_bytes, part_count, part_bytes,
           bad_range,
    input  ready
  );
  modport sink (
    input  valid, block_base, block_valid, offset_in_block, piece_length, data_offset,
           whole_block, last_piece, whole_count, whole_bytes, part_count, part_bytes,
           bad_range,
    output ready
  );
endinterface

// ===== sv/block_range_fragment_splitter.sv =====
// Channel  Dir  Fields
// rng      in   range_start, range_length
// frag     out  block_base, block_valid, offset_in_block, piece_length, data_offset,
//               whole_block, last_piece, whole/part count and bytes, bad_range
//
// One range at a time: a check state, a bit-serial start mod block size (48 steps
// and done) in the subtract/compare unit, a limit state, then prep, gen and hold states per
// fragment plus frag stalls, with an idle accept state before each range.
// Empty or out-of-file ranges skip the remainder and go to the result; over-limit after the limit check.
// rst is synchronous; registers come out of reset at file_length 1, block_length 1M.
// rng.ready is high only while idle; a pending result holds until frag.ready.
module block_range_fragment_splitter import brfs_pkg::*; #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int OFFSET_BITS   = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  reg_idx_t         wr_index,
  input  logic [CFG_W-1:0] wr_data,
  brfs_rng_if.sink         rng,
  brfs_frag_if.source      frag
);

  localparam logic [OFS_W-1:0] OFS_MASK =
    (OFFSET_BITS >= OFS_W) ? '1 : OFS_W'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] MAXF = CNT_W'(MAX_FRAGMENTS);
  localparam int LIM_W = BLK_W + CNT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_LIMIT = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_GEN   = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  state_t             state;
  logic [OFS_W-1:0]   file_length;
  logic [BLK_W-1:0]   block_length;
  logic [OFS_W-1:0]   start, len, fin, pos, base;
  logic [LIM_W-1:0]   lim;
  logic [BLK_W-1:0]   valid_len;
  logic [CNT_W-1:0]   wc, pc;
  logic [OFS_W-1:0]   wb, pb;
  rem_ctl_t           rctl;
  logic [INBLK_W-1:0] rem;

  logic               bad_early, bad_limit;
  logic [OFS_W-1:0]   room, bend, fend;
  logic [BLK_W-1:0]   piece;
  logic [INBLK_W-1:0] inblk;
  logic               whole, last;
  logic [CNT_W-1:0]   wc_next, pc_next;
  logic [OFS_W-1:0]   wb_next, pb_next;

  brfs_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (rctl.go),
    .dividend (start),
    .divisor  (block_length),
    .done     (rctl.done),
    .rem      (rem)
  );

  assign rng.ready  = (state == S_IDLE);
  assign frag.valid = (state == S_HOLD);

  assign bad_early = (block_length == '0) || (len == '0) || (start >= file_length) ||
                     (len > file_length - start);
  assign bad_limit = ({1'b0, len} + (OFS_W+1)'(rem)) > (OFS_W+1)'(lim);
  assign rctl.go   = (state == S_CHECK) && !bad_early;

  assign room    = file_length - base;
  assign bend    = base + OFS_W'(valid_len);
  assign fend    = (fin < bend) ? fin : bend;
  assign piece   = BLK_W'(fend - pos);
  assign inblk   = INBLK_W'(pos - base);
  assign whole   = (inblk == '0) && (piece == valid_len);
  assign last    = (fend >= fin);
  assign wc_next = wc + CNT_W'(whole);
  assign pc_next = pc + CNT_W'(!whole);
  assign wb_next = whole ? wb + OFS_W'(piece) : wb;
  assign pb_next = whole ? pb : pb + OFS_W'(piece);

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length  <= FILE_LENGTH_RST;
      block_length <= BLOCK_LENGTH_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_FILE_LENGTH:  file_length  <= wr_data[OFS_W-1:0];
        REG_BLOCK_LENGTH: block_length <= wr_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (rng.valid) state <= S_CHECK;
        S_CHECK: state <= bad_early ? S_HOLD : S_DIV;
        S_DIV:   if (rctl.done) state <= S_LIMIT;
        S_LIMIT: state <= bad_limit ? S_HOLD : S_PREP;
        S_PREP:  state <= S_GEN;
        S_GEN:   state <= S_HOLD;
        S_HOLD: begin
          if (frag.ready) state <= frag.last_piece ? S_IDLE : S_PREP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        start <= rng.range_start & OFS_MASK;
        len   <= rng.range_length & OFS_MASK;
        wc    <= '0;
        pc    <= '0;
        wb    <= '0;
        pb    <= '0;
      end
      S_CHECK: begin
        fin <= start + len;
        lim <= LIM_W'(block_length) * LIM_W'(MAXF);
      end
      S_LIMIT: begin
        pos  <= start;
        base <= start - OFS_W'(rem);
      end
      S_PREP: begin
        valid_len <= ({{(OFS_W-BLK_W){1'b0}}, block_length} < room) ?
                     block_length : room[BLK_W-1:0];
      end
      S_GEN: begin
        pos  <= fend;
        base <= bend;
        wc   <= wc_next;
        pc   <= pc_next;
        wb   <= wb_next;
        pb   <= pb_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (((state == S_CHECK) && bad_early) || ((state == S_LIMIT) && bad_limit)) begin
      frag.block_base      <= '0;
      frag.block_valid     <= '0;
      frag.offset_in_block <= '0;
      frag.piece_length    <= '0;
      frag.data_offset     <= '0;
      frag.whole_block     <= 1'b0;
      frag.last_piece      <= 1'b1;
      frag.whole_count     <= '0;
      frag.whole_bytes     <= '0;
      frag.part_count      <= '0;
      frag.part_bytes      <= '0;
      frag.bad_range       <= 1'b1;
    end else if (state == S_GEN) begin
      frag.block_base      <= base;
      frag.block_valid     <= valid_len;
      frag.offset_in_block <= inblk;
      frag.piece_length    <= piece;
      frag.data_offset     <= pos - start;
      frag.whole_block     <= whole;
      frag.last_piece      <= last;
      frag.whole_count     <= wc_next;
      frag.whole_bytes     <= wb_next;
      frag.part_count      <= pc_next;
      frag.part_bytes      <= pb_next;
      frag.bad_range       <= 1'b0;
    end
  end

endmodule

// ===== sv/brfs_rem_unit.sv =====
// restoring remainder, one dividend bit per cycle
module brfs_rem_unit import brfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [OFS_W-1:0]   dividend,
  input  logic [BLK_W-1:0]   divisor,
  output logic               done,
  output logic [INBLK_W-1:0] rem
);

  localparam int CW = $clog2(OFS_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [OFS_W-1:0] dvd;
  logic [BLK_W-1:0] sh;

  assign sh = {rem, dvd[OFS_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(OFS_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[OFS_W-2:0], 1'b0};
      if (sh >= divisor) begin
        rem <= INBLK_W'(sh - divisor);
      end else begin
        rem <= sh[INBLK_W-1:0];
      end
    end
  end

endmodule

// ===== sv/brfs_checker.sv =====
`include "block_range_fragment_splitter_defines.svh"

module brfs_checker import brfs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rng_ready,
  input logic               frag_valid,
  input logic               frag_ready,
  input logic [OFS_W-1:0]   block_base,
  input logic [BLK_W-1:0]   block_valid,
  input logic [INBLK_W-1:0] offset_in_block,
  input logic [BLK_W-1:0]   piece_length,
  input logic               whole_block,
  input logic               last_piece,
  input logic [CNT_W-1:0]   whole_count,
  input logic [CNT_W-1:0]   part_count,
  input logic               bad_range
);

  `BRFS_ASSERT_NEXT(a_frag_hold, frag_valid && !frag_ready, frag_valid && $stable(block_base) && $stable(piece_length) && $stable(last_piece), "frag request changed while stalled")
  `BRFS_ASSERT_NOW(a_bad_alone, frag_valid && bad_range, last_piece && !whole_block && piece_length == '0 && block_base == '0 && whole_count == '0 && part_count == '0, "bad range result not clean")
  `BRFS_ASSERT_NOW(a_whole_ok, frag_valid && whole_block, offset_in_block == '0 && piece_length == block_valid, "whole block flag inconsistent")
  `BRFS_ASSERT_NOW(a_good_piece, frag_valid && !bad_range, piece_length != '0 && (whole_count != '0 || part_count != '0), "empty fragment")
  `BRFS_ASSERT_NOW(a_one_range, frag_valid, !rng_ready, "new range taken while result pending")

endmodule

bind block_range_fragment_splitter brfs_checker u_brfs_checker (
  .clk             (clk),
  .rst             (rst),
  .rng_ready       (rng.ready),
  .frag_valid      (frag.valid),
  .frag_ready      (frag.ready),
  .block_base      (frag.block_base),
  .block_valid     (frag.block_valid),
  .offset_in_block (frag.offset_in_block),
  .piece_length    (frag.piece_length),
  .whole_block     (frag.whole_block),
  .last_piece      (frag.last_piece),
  .whole_count     (frag.whole_count),
  .part_count      (frag.part_count),
  .bad_range       (frag.bad_range)
);

// ===== tb/block_range_fragment_splitter_test.sv =====
`timescale 1ns / 1ps

module block_range_fragment_splitter_test;
  import brfs_pkg::*;

  localparam int FRAG_LIMIT = 64;
  localparam reg_idx_t REG_SPARE_2 = 2'd2;
  localparam reg_idx_t REG_SPARE_3 = 2'd3;
  localparam longint unsigned BLOCK_MAX = 64'h1_0000_0000;

  typedef struct packed {
    logic [OFS_W-1:0] range_start;
    logic [OFS_W-1:0] range_length;
  } range_req_t;

  typedef struct packed {
    logic [OFS_W-1:0]   block_base;
    logic [BLK_W-1:0]   block_valid;
    logic [INBLK_W-1:0] offset_in_block;
    logic [BLK_W-1:0]   piece_length;
    logic [OFS_W-1:0]   data_offset;
    logic               whole_block;
    logic               last_piece;
    logic [CNT_W-1:0]   whole_count;
    logic [OFS_W-1:0]   whole_bytes;
    logic [CNT_W-1:0]   part_count;
    logic [OFS_W-1:0]   part_bytes;
    logic               bad_range;
  } frag_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  reg_idx_t wr_index;
  logic [CFG_W-1:0] wr_data;

  brfs_rng_if  rng_ch ();
  brfs_frag_if frag_ch ();

  block_range_fragment_splitter #(
    .MAX_FRAGMENTS(FRAG_LIMIT),
    .OFFSET_BITS(OFS_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .rng(rng_ch),
    .frag(frag_ch)
  );

  always #1 clk = ~clk;

  range_req_t range_q[$];
  frag_t due_frags[$];
  logic [OFS_W-1:0] cfg_file_length;
  logic [BLK_W-1:0] cfg_block_length;
  int pushed_total = 0;
  int taken_total = 0;
  int errors = 0;
  bit steady = 1'b0;
  bit rng_taken = 1'b0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  function automatic longint unsigned rand_bits(int n);
    longint unsigned v;
    v = {$urandom, $urandom};
    return (n >= 64) ? v : (v & ((64'd1 << n) - 1));
  endfunction

  // expected fragments of one range under the current register values
  function automatic void split_range(logic [OFS_W-1:0] s_in, logic [OFS_W-1:0] l_in);
    longint unsigned s, l, flen, blen, stop, pos, base, room, vsize, bend, fend, piece, inblk;
    longint unsigned wc, wb, pc, pb, nblk;
    bit bad;
    frag_t f;
    s = 64'(s_in);
    l = 64'(l_in);
    flen = 64'(cfg_file_length);
    blen = 64'(cfg_block_length);
    wc = 0; wb = 0; pc = 0; pb = 0;
    bad = (blen == 0) || (l == 0) || (s >= flen) || (l > flen - s);
    if (!bad) begin
      nblk = (s + l - 1) / blen - s / blen + 1;
      bad = nblk > FRAG_LIMIT;
    end
    if (bad) begin
      f = '0;
      f.last_piece = 1'b1;
      f.bad_range = 1'b1;
      due_frags.push_back(f);
      return;
    end
    stop = s + l;
    pos = s;
    while (pos < stop) begin
      base = pos / blen * blen;
      room = flen - base;
      vsize = (blen < room) ? blen : room;
      bend = base + vsize;
      fend = (stop < bend) ? stop : bend;
      piece = fend - pos;
      inblk = pos - base;
      f = '0;
      f.whole_block = (inblk == 0) && (piece == vsize);
      if (f.whole_block) begin
        wc++;
        wb += piece;
      end else begin
        pc++;
        pb += piece;
      end
      f.block_base = OFS_W'(base);
      f.block_valid = BLK_W'(vsize);
      f.offset_in_block = INBLK_W'(inblk);
      f.piece_length = BLK_W'(piece);
      f.data_offset = OFS_W'(pos - s);
      f.last_piece = fend >= stop;
      f.whole_count = CNT_W'(wc);
      f.whole_bytes = OFS_W'(wb);
      f.part_count = CNT_W'(pc);
      f.part_bytes = OFS_W'(pb);
      due_frags.push_back(f);
      pos = fend;
    end
  endfunction

  function automatic void cmp(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // register shadow, prediction on request accept, check on fragment accept
  always @(posedge clk) begin
    frag_t got, want;
    rng_taken <= rng_ch.valid && rng_ch.ready;
    if (rst) begin
      cfg_file_length = FILE_LENGTH_RST;
      cfg_block_length = BLOCK_LENGTH_RST;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_FILE_LENGTH: cfg_file_length = wr_data[OFS_W-1:0];
          REG_BLOCK_LENGTH: cfg_block_length = wr_data[BLK_W-1:0];
          default: ;
        endcase
      end
      if (rng_ch.valid && rng_ch.ready) begin
        split_range(rng_ch.range_start, rng_ch.range_length);
        taken_total++;
      end
      if (frag_ch.valid && frag_ch.ready) begin
        got.block_base = frag_ch.block_base;
        got.block_valid = frag_ch.block_valid;
        got.offset_in_block = frag_ch.offset_in_block;
        got.piece_length = frag_ch.piece_length;
        got.data_offset = frag_ch.data_offset;
        got.whole_block = frag_ch.whole_block;
        got.last_piece = frag_ch.last_piece;
        got.whole_count = frag_ch.whole_count;
        got.whole_bytes = frag_ch.whole_bytes;
        got.part_count = frag_ch.part_count;
        got.part_bytes = frag_ch.part_bytes;
        got.bad_range = frag_ch.bad_range;
        if (due_frags.size() == 0) begin
          $display("%0t: unexpected fragment, expected none got base %0h len %0h",
                   $time, got.block_base, got.piece_length);
          errors++;
        end else begin
          want = due_frags.pop_front();
          cmp("block_base", 64'(want.block_base), 64'(got.block_base));
          cmp("block_valid", 64'(want.block_valid), 64'(got.block_valid));
          cmp("offset_in_block", 64'(want.offset_in_block), 64'(got.offset_in_block));
          cmp("piece_length", 64'(want.piece_length), 64'(got.piece_length));
          cmp("data_offset", 64'(want.data_offset), 64'(got.data_offset));
          cmp("whole_block", 64'(want.whole_block), 64'(got.whole_block));
          cmp("last_piece", 64'(want.last_piece), 64'(got.last_piece));
          cmp("whole_count", 64'(want.whole_count), 64'(got.whole_count));
          cmp("whole_bytes", 64'(want.whole_bytes), 64'(got.whole_bytes));
          cmp("part_count", 64'(want.part_count), 64'(got.part_count));
          cmp("part_bytes", 64'(want.part_bytes), 64'(got.part_bytes));
          cmp("bad_range", 64'(want.bad_range), 64'(got.bad_range));
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    range_req_t nxt;
    if (rst) begin
      rng_ch.valid <= 1'b0;
    end else if (!rng_ch.valid || rng_taken) begin
      if (range_q.size() > 0 && (steady || $urandom_range(99) >= 7)) begin
        nxt = range_q.pop_front();
        rng_ch.valid <= 1'b1;
        rng_ch.range_start <= nxt.range_start;
        rng_ch.range_length <= nxt.range_length;
      end else begin
        rng_ch.valid <= 1'b0;
      end
    end
  end

  // fragment receiver, with one long hold-off while requests keep coming
  always @(negedge clk) begin
    if (rst) begin
      frag_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      frag_ch.ready <= 1'b0;
    end else if (!stall_done && taken_total >= 150) begin
      stall_left <= 400;
      stall_done <= 1'b1;
      frag_ch.ready <= 1'b0;
    end else begin
      frag_ch.ready <= steady || ($urandom_range(99) >= 7);
    end
  end

  task automatic send(longint unsigned s, longint unsigned l);
    range_req_t r;
    r.range_start = OFS_W'(s);
    r.range_length = OFS_W'(l);
    range_q.push_back(r);
    pushed_total++;
  endtask

  task automatic drain();
    while (!(taken_total == pushed_total && due_frags.size() == 0)) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic send_random(longint unsigned flen, longint unsigned blen);
    longint unsigned s, l, span, room, k;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send(rand_bits($urandom_range(1, 48)), rand_bits($urandom_range(1, 48)));
    end else if (pick < 11) begin
      send(rand_bits(48) % flen, 0);
    end else if (pick < 14) begin
      send(flen + rand_bits($urandom_range(0, 20)), $urandom_range(1, 100));
    end else begin
      s = rand_bits(48) % flen;
      if ($urandom_range(3) == 0) s = s / blen * blen;
      if (pick < 18) k = $urandom_range(65, 68);
      else if ($urandom_range(9) == 0) k = $urandom_range(1, FRAG_LIMIT);
      else k = $urandom_range(1, 6);
      span = (s / blen + k) * blen - s;
      room = flen - s;
      if (pick >= 18 && span > room) span = room;
      l = ($urandom_range(2) == 0) ? span : 1 + rand_bits(48) % span;
      send(s, l);
    end
  endtask

  initial begin
    longint unsigned flen, blen;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_FILE_LENGTH;
    wr_data = '0;
    rng_ch.valid = 1'b0;
    rng_ch.range_start = '0;
    rng_ch.range_length = '0;
    frag_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // out of reset: one-byte file
    send(0, 1);
    send(0, 0);
    send(1, 1);
    drain();

    set_reg(REG_FILE_LENGTH, 48'd1000);
    set_reg(REG_BLOCK_LENGTH, 48'd100);
    set_reg(REG_SPARE_2, 48'hFFFF_FFFF_FFFF);
    set_reg(REG_SPARE_3, 48'h0);
    send(0, 1000);
    send(50, 100);
    send(999, 1);
    send(0, 0);
    send(1000, 1);
    send(10, 991);
    send(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    drain();

    // short last block
    set_reg(REG_FILE_LENGTH, 48'd1050);
    send(1000, 50);
    send(1020, 20);
    send(0, 1050);
    drain();

    // fragment limit edge
    set_reg(REG_BLOCK_LENGTH, 48'd10);
    send(0, 640);
    send(0, 641);
    send(5, 640);
    send(5, 635);
    drain();

    set_reg(REG_FILE_LENGTH, 48'hFFFF_FFFF_FFFF);
    set_reg(REG_BLOCK_LENGTH, 48'h1_0000_0000);
    send(48'hFFFC_0000_0000, 48'h3_FFFF_FFFF);
    send(48'hFFFF_0000_0001, 48'hFFFF_FFFE);
    drain();

    // upper bits dropped: block size becomes zero
    set_reg(REG_BLOCK_LENGTH, 48'h2_0000_0000);
    send(0, 1);
    drain();

    set_reg(REG_FILE_LENGTH, 48'd65);
    set_reg(REG_BLOCK_LENGTH, 48'd1);
    send(0, 64);
    send(1, 64);
    send(0, 65);
    drain();

    set_reg(REG_FILE_LENGTH, 48'd0);
    set_reg(REG_BLOCK_LENGTH, 48'd5);
    send(0, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      flen = rand_bits($urandom_range(1, 48));
      if (flen == 0) flen = 1;
      case ($urandom_range(3))
        0: blen = $urandom_range(1, 16);
        1: blen = $urandom_range(1, 4096);
        2: blen = rand_bits(33);
        default: blen = flen / $urandom_range(1, 70) + 1;
      endcase
      if (blen > BLOCK_MAX) blen = BLOCK_MAX;
      if (blen == 0) blen = 1;
      set_reg(REG_FILE_LENGTH, CFG_W'(flen));
      set_reg(REG_BLOCK_LENGTH, CFG_W'((rand_bits(15) << BLK_W) | blen));
      steady = (ph == 3);
      repeat (53) send_random(flen, blen);
      drain();
    end
    steady = 1'b0;

    repeat (60) @(negedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
